[rtl/nnis_pkg.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// nnis_pkg
// Shared types, widths and helpers of the nearest-neighbor image scaler.
// ----------------------------------------------------------------------------
package nnis_pkg;

	// default parameter values of the top level
	localparam int DEF_MAX_WIDTH    = 256;
	localparam int DEF_MAX_HEIGHT   = 256;
	localparam int DEF_CHANNEL_BITS = 8;

	// field widths
	localparam int DIM_W   = 9;                // in_width, in_height
	localparam int ODIM_W  = 13;               // out_width, out_height
	localparam int COORD_W = 12;               // out_row, out_col
	localparam int NUM_W   = COORD_W + DIM_W;  // coordinate times source size
	localparam int QUOT_W  = DIM_W;            // source row / column
	localparam int DSH_W   = ODIM_W + QUOT_W - 1;
	localparam int CMP_W   = (NUM_W > DSH_W) ? NUM_W : DSH_W;
	localparam int STEP_W  = $clog2(QUOT_W);

	// configuration port
	localparam int PADDR_W   = 4;
	localparam int PDATA_W   = 32;
	localparam int REG_IDX_W = 2;
	localparam logic [REG_IDX_W-1:0] REG_IN_WIDTH   = 2'd0;
	localparam logic [REG_IDX_W-1:0] REG_IN_HEIGHT  = 2'd1;
	localparam logic [REG_IDX_W-1:0] REG_OUT_WIDTH  = 2'd2;
	localparam logic [REG_IDX_W-1:0] REG_OUT_HEIGHT = 2'd3;

	localparam logic [DIM_W-1:0]  RST_IN_DIM  = DIM_W'(256);
	localparam logic [ODIM_W-1:0] RST_OUT_DIM = ODIM_W'(256);

	// input item kind
	localparam logic KIND_LOAD  = 1'b0;
	localparam logic KIND_FETCH = 1'b1;

	localparam int QUEUE_DEPTH = 4;

	typedef struct packed {
		logic [DIM_W-1:0]  in_w;
		logic [DIM_W-1:0]  in_h;
		logic [ODIM_W-1:0] out_w;
		logic [ODIM_W-1:0] out_h;
	} cfg_t;

	localparam int CMD_KIND_W = 2;
	typedef enum logic [CMD_KIND_W-1:0] {
		CMD_LOAD  = 2'd0,
		CMD_FETCH = 2'd1,
		CMD_ERR   = 2'd2
	} cmd_kind_t;

	// source size forced into 1..maxv
	function automatic logic [DIM_W-1:0] clamp_dim(input logic [DIM_W-1:0] v,
			input int unsigned maxv);
		logic [DIM_W-1:0] r;
		r = v;
		if (v == '0)
			r = DIM_W'(1);
		else if (32'(v) > maxv)
			r = DIM_W'(maxv);
		return r;
	endfunction

endpackage

[rtl/nnis_front.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// nnis_front
// Accepts items, keeps the load address, checks fetch coordinates and forms
// the scaled numerators, then queues one command per item.
// ----------------------------------------------------------------------------
module nnis_front import nnis_pkg::*; #(
	parameter int MAX_WIDTH    = DEF_MAX_WIDTH,
	parameter int MAX_HEIGHT   = DEF_MAX_HEIGHT,
	parameter int CHANNEL_BITS = DEF_CHANNEL_BITS,
	localparam int DEPTH  = MAX_WIDTH * MAX_HEIGHT,
	localparam int ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1,
	localparam int CMDV_W = CMD_KIND_W + ADDR_W + 3 * CHANNEL_BITS + 2 * NUM_W
) (
	input  logic                    clk,
	input  logic                    arst_n,
	input  cfg_t                    cfg,
	input  logic                    in_valid,
	output logic                    in_stall,
	input  logic                    kind,
	input  logic [CHANNEL_BITS-1:0] load_red,
	input  logic [CHANNEL_BITS-1:0] load_green,
	input  logic [CHANNEL_BITS-1:0] load_blue,
	input  logic                    load_first,
	input  logic [COORD_W-1:0]      out_row,
	input  logic [COORD_W-1:0]      out_col,
	input  logic                    q_full,
	output logic                    q_push,
	output logic [CMDV_W-1:0]       q_data
);

	logic [ADDR_W-1:0] load_addr_q;
	logic [ADDR_W-1:0] wr_addr;
	logic [DIM_W-1:0]  iw, ih;
	logic [NUM_W-1:0]  num_row, num_col;
	logic              err;
	cmd_kind_t         cmd;

	assign in_stall = q_full;
	assign q_push   = in_valid && !q_full;

	assign wr_addr = load_first ? '0 : load_addr_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			load_addr_q <= '0;
		end else if (q_push && kind == KIND_LOAD) begin
			load_addr_q <= (wr_addr == ADDR_W'(DEPTH - 1)) ? '0 : wr_addr + 1'b1;
		end
	end

	assign iw = clamp_dim(cfg.in_w, MAX_WIDTH);
	assign ih = clamp_dim(cfg.in_h, MAX_HEIGHT);

	assign err = (cfg.out_w == '0) || (cfg.out_h == '0) ||
		(ODIM_W'(out_row) >= cfg.out_h) || (ODIM_W'(out_col) >= cfg.out_w);

	assign num_row = NUM_W'(out_row) * NUM_W'(ih);
	assign num_col = NUM_W'(out_col) * NUM_W'(iw);

	always_comb begin
		if (kind == KIND_LOAD)
			cmd = CMD_LOAD;
		else if (err)
			cmd = CMD_ERR;
		else
			cmd = CMD_FETCH;
	end

	assign q_data = {cmd, wr_addr, load_red, load_green, load_blue, num_row, num_col};

endmodule

[rtl/nnis_queue.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// nnis_queue
// Small first-in first-out command queue between front and back.
// ----------------------------------------------------------------------------
module nnis_queue import nnis_pkg::*; #(
	parameter int WIDTH = 8,
	parameter int DEPTH = QUEUE_DEPTH,
	localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1,
	localparam int CNT_W = $clog2(DEPTH + 1)
) (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             push,
	input  logic [WIDTH-1:0] push_data,
	input  logic             pop,
	output logic [WIDTH-1:0] head,
	output logic             full,
	output logic             empty
);

	logic [WIDTH-1:0] slot_q [DEPTH];
	logic [PTR_W-1:0] wr_ptr_q, rd_ptr_q;
	logic [CNT_W-1:0] count_q;

	assign full  = (count_q == CNT_W'(DEPTH));
	assign empty = (count_q == '0);
	assign head  = slot_q[rd_ptr_q];

	always_ff @(posedge clk) begin
		if (push)
			slot_q[wr_ptr_q] <= push_data;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (push)
				wr_ptr_q <= (wr_ptr_q == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_q + 1'b1;
			if (pop)
				rd_ptr_q <= (rd_ptr_q == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_q + 1'b1;
			if (push && !pop)
				count_q <= count_q + 1'b1;
			else if (pop && !push)
				count_q <= count_q - 1'b1;
		end
	end

endmodule

[rtl/nnis_back.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// nnis_back
// Executes queued commands: frame store writes, the two source-coordinate
// divisions, the store read and the output register.
// ----------------------------------------------------------------------------
module nnis_back import nnis_pkg::*; #(
	parameter int MAX_WIDTH    = DEF_MAX_WIDTH,
	parameter int MAX_HEIGHT   = DEF_MAX_HEIGHT,
	parameter int CHANNEL_BITS = DEF_CHANNEL_BITS,
	localparam int DEPTH  = MAX_WIDTH * MAX_HEIGHT,
	localparam int ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1,
	localparam int PIX_W  = 3 * CHANNEL_BITS,
	localparam int CMDV_W = CMD_KIND_W + ADDR_W + PIX_W + 2 * NUM_W
) (
	input  logic                    clk,
	input  logic                    arst_n,
	input  cfg_t                    cfg,
	input  logic [CMDV_W-1:0]       q_head,
	input  logic                    q_empty,
	output logic                    q_pop,
	output logic                    out_valid,
	input  logic                    out_stall,
	output logic [CHANNEL_BITS-1:0] pix_red,
	output logic [CHANNEL_BITS-1:0] pix_green,
	output logic [CHANNEL_BITS-1:0] pix_blue,
	output logic                    coord_error
);

	localparam int NC_LSB = 0;
	localparam int NR_LSB = NUM_W;
	localparam int PX_LSB = 2 * NUM_W;
	localparam int AD_LSB = PX_LSB + PIX_W;
	localparam int KD_LSB = AD_LSB + ADDR_W;

	typedef enum logic [4:0] {
		ST_IDLE = 5'b00001,
		ST_DIV  = 5'b00010,
		ST_ADDR = 5'b00100,
		ST_READ = 5'b01000,
		ST_DONE = 5'b10000
	} bk_state_t;

	bk_state_t state_q;

	cmd_kind_t         h_kind;
	logic [ADDR_W-1:0] h_addr;
	logic [PIX_W-1:0]  h_pix;
	logic [NUM_W-1:0]  h_num_row, h_num_col;

	logic [CMP_W-1:0]  rem_r_q, rem_c_q, dsh_r_q, dsh_c_q;
	logic [QUOT_W-1:0] quo_r_q, quo_c_q;
	logic [STEP_W-1:0] step_q;
	logic              ge_r, ge_c;

	logic [DIM_W-1:0]   iw;
	logic [2*DIM_W-1:0] lin;
	logic [ADDR_W-1:0]  rd_addr_q;
	logic [PIX_W-1:0]   rd_data_q;
	logic               wr_en, rd_en;

	logic [PIX_W-1:0]  store [DEPTH];

	logic              out_valid_q, out_err_q;
	logic [PIX_W-1:0]  out_pix_q;
	logic              out_free, out_load_err, out_load_pix;

	assign h_kind    = cmd_kind_t'(q_head[KD_LSB +: CMD_KIND_W]);
	assign h_addr    = q_head[AD_LSB +: ADDR_W];
	assign h_pix     = q_head[PX_LSB +: PIX_W];
	assign h_num_row = q_head[NR_LSB +: NUM_W];
	assign h_num_col = q_head[NC_LSB +: NUM_W];

	assign out_free = !out_valid_q || !out_stall;

	// an error result goes straight to the output register, so its pop waits until that register is free
	assign q_pop = (state_q == ST_IDLE) && !q_empty && (h_kind != CMD_ERR || out_free);

	assign wr_en        = q_pop && h_kind == CMD_LOAD;
	assign out_load_err = q_pop && h_kind == CMD_ERR;
	assign out_load_pix = (state_q == ST_DONE) && out_free;
	assign rd_en        = (state_q == ST_READ);

	assign ge_r = (rem_r_q >= dsh_r_q);
	assign ge_c = (rem_c_q >= dsh_c_q);

	assign iw  = clamp_dim(cfg.in_w, MAX_WIDTH);
	assign lin = {{DIM_W{1'b0}}, quo_r_q} * {{DIM_W{1'b0}}, iw} + {{DIM_W{1'b0}}, quo_c_q};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
		end else begin
			case (state_q)
				ST_IDLE: begin
					if (q_pop && h_kind == CMD_FETCH)
						state_q <= ST_DIV;
				end
				ST_DIV: begin
					if (step_q == STEP_W'(QUOT_W - 1))
						state_q <= ST_ADDR;
				end
				ST_ADDR: state_q <= ST_READ;
				ST_READ: state_q <= ST_DONE;
				ST_DONE: begin
					if (out_free)
						state_q <= ST_IDLE;
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end

	// restoring division, one quotient bit per cycle for row and column
	always_ff @(posedge clk) begin
		if (q_pop && h_kind == CMD_FETCH) begin
			rem_r_q <= CMP_W'(h_num_row);
			rem_c_q <= CMP_W'(h_num_col);
			dsh_r_q <= CMP_W'(cfg.out_h) << (QUOT_W - 1);
			dsh_c_q <= CMP_W'(cfg.out_w) << (QUOT_W - 1);
			step_q  <= '0;
		end else if (state_q == ST_DIV) begin
			if (ge_r)
				rem_r_q <= rem_r_q - dsh_r_q;
			if (ge_c)
				rem_c_q <= rem_c_q - dsh_c_q;
			quo_r_q <= {quo_r_q[QUOT_W-2:0], ge_r};
			quo_c_q <= {quo_c_q[QUOT_W-2:0], ge_c};
			dsh_r_q <= dsh_r_q >> 1;
			dsh_c_q <= dsh_c_q >> 1;
			step_q  <= step_q + 1'b1;
		end
		if (state_q == ST_ADDR)
			rd_addr_q <= ADDR_W'(lin);
	end

	always_ff @(posedge clk) begin
		if (wr_en)
			store[h_addr] <= h_pix;
		if (rd_en)
			rd_data_q <= store[rd_addr_q];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (out_load_err || out_load_pix) begin
			out_valid_q <= 1'b1;
		end else if (!out_stall) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (out_load_err) begin
			out_pix_q <= '0;
			out_err_q <= 1'b1;
		end else if (out_load_pix) begin
			out_pix_q <= rd_data_q;
			out_err_q <= 1'b0;
		end
	end

	assign out_valid   = out_valid_q;
	assign coord_error = out_err_q;
	assign pix_red     = out_pix_q[2*CHANNEL_BITS +: CHANNEL_BITS];
	assign pix_green   = out_pix_q[CHANNEL_BITS +: CHANNEL_BITS];
	assign pix_blue    = out_pix_q[0 +: CHANNEL_BITS];

endmodule

[rtl/nearest_neighbor_image_scaler_core.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// nearest_neighbor_image_scaler_core
// Frame store loader and nearest-neighbor fetch unit with register port.
// ----------------------------------------------------------------------------
//  channel | handshake                   | payload
//  --------+-----------------------------+-----------------------------------
//  input   | in_valid / in_stall         | kind, load_*, load_first, out_row/col
//  output  | out_valid / out_stall       | pix_red/green/blue, coord_error
//  config  | psel, penable, pwrite       | paddr, pwdata, prdata (pready = 1)
//
//  A load item or a rejected fetch is done at its pop.
//  A fetch runs through pop, nine divider steps, address multiply,
//  registered store read and output load; the load waits out an output stall.
//  Reset clears control state only; the frame store is not cleared.
//  A four-entry queue lets items enter while the back end works or the output
//  is stalled; in_stall rises only when that queue is full.
// ----------------------------------------------------------------------------
module nearest_neighbor_image_scaler_core import nnis_pkg::*; #(
	parameter int MAX_WIDTH    = DEF_MAX_WIDTH,
	parameter int MAX_HEIGHT   = DEF_MAX_HEIGHT,
	parameter int CHANNEL_BITS = DEF_CHANNEL_BITS
) (
	input  logic                    clk,
	input  logic                    arst_n,
	input  logic                    psel,
	input  logic                    penable,
	input  logic                    pwrite,
	input  logic [PADDR_W-1:0]      paddr,
	input  logic [PDATA_W-1:0]      pwdata,
	output logic [PDATA_W-1:0]      prdata,
	output logic                    pready,
	input  logic                    in_valid,
	output logic                    in_stall,
	input  logic                    kind,
	input  logic [CHANNEL_BITS-1:0] load_red,
	input  logic [CHANNEL_BITS-1:0] load_green,
	input  logic [CHANNEL_BITS-1:0] load_blue,
	input  logic                    load_first,
	input  logic [COORD_W-1:0]      out_row,
	input  logic [COORD_W-1:0]      out_col,
	output logic                    out_valid,
	input  logic                    out_stall,
	output logic [CHANNEL_BITS-1:0] pix_red,
	output logic [CHANNEL_BITS-1:0] pix_green,
	output logic [CHANNEL_BITS-1:0] pix_blue,
	output logic                    coord_error
);

	localparam int DEPTH  = MAX_WIDTH * MAX_HEIGHT;
	localparam int ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam int CMDV_W = CMD_KIND_W + ADDR_W + 3 * CHANNEL_BITS + 2 * NUM_W;

	cfg_t                 cfg_q;
	logic                 cfg_wr;
	logic [REG_IDX_W-1:0] reg_idx;

	logic              q_push, q_pop, q_full, q_empty;
	logic [CMDV_W-1:0] q_data, q_head;

	assign pready  = 1'b1;
	assign reg_idx = paddr[PADDR_W-1:2];
	assign cfg_wr  = psel && penable && pwrite && pready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.in_w  <= RST_IN_DIM;
			cfg_q.in_h  <= RST_IN_DIM;
			cfg_q.out_w <= RST_OUT_DIM;
			cfg_q.out_h <= RST_OUT_DIM;
		end else if (cfg_wr) begin
			case (reg_idx)
				REG_IN_WIDTH:   cfg_q.in_w  <= pwdata[DIM_W-1:0];
				REG_IN_HEIGHT:  cfg_q.in_h  <= pwdata[DIM_W-1:0];
				REG_OUT_WIDTH:  cfg_q.out_w <= pwdata[ODIM_W-1:0];
				REG_OUT_HEIGHT: cfg_q.out_h <= pwdata[ODIM_W-1:0];
				default: ;
			endcase
		end
	end

	always_comb begin
		case (reg_idx)
			REG_IN_WIDTH:   prdata = PDATA_W'(cfg_q.in_w);
			REG_IN_HEIGHT:  prdata = PDATA_W'(cfg_q.in_h);
			REG_OUT_WIDTH:  prdata = PDATA_W'(cfg_q.out_w);
			REG_OUT_HEIGHT: prdata = PDATA_W'(cfg_q.out_h);
			default:        prdata = '0;
		endcase
	end

	nnis_front #(
		.MAX_WIDTH    (MAX_WIDTH),
		.MAX_HEIGHT   (MAX_HEIGHT),
		.CHANNEL_BITS (CHANNEL_BITS)
	) u_front (
		.clk        (clk),
		.arst_n     (arst_n),
		.cfg        (cfg_q),
		.in_valid   (in_valid),
		.in_stall   (in_stall),
		.kind       (kind),
		.load_red   (load_red),
		.load_green (load_green),
		.load_blue  (load_blue),
		.load_first (load_first),
		.out_row    (out_row),
		.out_col    (out_col),
		.q_full     (q_full),
		.q_push     (q_push),
		.q_data     (q_data)
	);

	nnis_queue #(
		.WIDTH (CMDV_W),
		.DEPTH (QUEUE_DEPTH)
	) u_queue (
		.clk       (clk),
		.arst_n    (arst_n),
		.push      (q_push),
		.push_data (q_data),
		.pop       (q_pop),
		.head      (q_head),
		.full      (q_full),
		.empty     (q_empty)
	);

	nnis_back #(
		.MAX_WIDTH    (MAX_WIDTH),
		.MAX_HEIGHT   (MAX_HEIGHT),
		.CHANNEL_BITS (CHANNEL_BITS)
	) u_back (
		.clk         (clk),
		.arst_n      (arst_n),
		.cfg         (cfg_q),
		.q_head      (q_head),
		.q_empty     (q_empty),
		.q_pop       (q_pop),
		.out_valid   (out_valid),
		.out_stall   (out_stall),
		.pix_red     (pix_red),
		.pix_green   (pix_green),
		.pix_blue    (pix_blue),
		.coord_error (coord_error)
	);

`ifndef ASSERT_OFF
	a_no_pop_empty: assert property (@(posedge clk) disable iff (!arst_n)
		!(q_pop && q_empty))
		else $error("command popped from empty queue");

	a_no_push_full: assert property (@(posedge clk) disable iff (!arst_n)
		!(q_push && q_full))
		else $error("command pushed into full queue");

	a_err_zero_pix: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid && coord_error) |-> (pix_red == '0 && pix_green == '0 && pix_blue == '0))
		else $error("rejected coordinate item carries nonzero color");

	a_err_from_queue: assert property (@(posedge clk) disable iff (!arst_n)
		($rose(out_valid) && coord_error) |-> $past(q_pop))
		else $error("error item appeared without a queue pop");
`endif

endmodule
